// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HeapBytesDef  = 65536;
  localparam int unsigned TableDepthDef = 64;

  localparam int unsigned AddrW = 16;
  localparam int unsigned SizeW = 17;
  localparam int unsigned StatW = 3;

  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_ZERO     = 3'd1;
  localparam logic [StatW-1:0] ST_NOSPACE  = 3'd2;
  localparam logic [StatW-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [StatW-1:0] ST_FULL     = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COAL,
    S_FIT,
    S_FREM,
    S_UINS,
    S_FINS,
    S_USRCH,
    S_UREM,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/first_fit_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator core
// Each sequencer step moves one table entry; a zero-size allocate skips the
// table passes and goes straight to the result.
// One request is in flight at a time; in_ready is high again right after the
// result transfer. Synchronous reset restores one free chunk covering the
// whole heap and an empty used table.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES  = HeapBytesDef,
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  input  logic [SizeW-1:0] in_req_size,
  input  logic [AddrW-1:0] in_req_addr,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [AddrW-1:0] out_chunk_addr,
  output logic [StatW-1:0] out_status
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW = $clog2(HEAP_BYTES + 1);
  localparam int unsigned SW = (LW > AddrW) ? LW : AddrW;
  localparam int unsigned ZW = (LW > SizeW) ? LW : SizeW;
  localparam int unsigned FW = SW + LW;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Chunk tables, one {start, length} word per entry, read with registered data.
  logic [FW-1:0] fmem_r [TABLE_DEPTH];
  logic [FW-1:0] umem_r [TABLE_DEPTH];
  logic [FW-1:0] f_q_r, u_q_r;
  logic [SW-1:0] f_q_s, u_q_s;
  logic [LW-1:0] f_q_l, u_q_l;

  logic [IW-1:0] f_raddr, f_waddr, u_raddr, u_waddr;
  logic          f_we, u_we;
  logic [FW-1:0] f_wdata, u_wdata;

  state_t           st_r, st_nxt;
  logic [CW-1:0]    fcnt_r, fcnt_nxt, ucnt_r, ucnt_nxt;
  logic [CW-1:0]    rd_r, rd_nxt, wr_r, wr_nxt;
  logic             pr_r, pr_nxt;
  logic             type_r, type_nxt;
  logic [ZW-1:0]    size_r, size_nxt;
  logic [SW-1:0]    addr_r, addr_nxt;
  logic [SW-1:0]    cs_r, cs_nxt;
  logic [LW-1:0]    cl_r, cl_nxt;
  logic [AddrW-1:0] res_addr_r, res_addr_nxt;
  logic [StatW-1:0] res_stat_r, res_stat_nxt;
  logic             ov_r, ov_nxt;

  logic [IW-1:0] ri, rip1, rip2, rim1, rim2, wi;

  assign in_ready       = (st_r == S_IDLE);
  assign out_valid      = ov_r;
  assign out_chunk_addr = res_addr_r;
  assign out_status     = res_stat_r;

  assign f_q_s = f_q_r[FW-1:LW];
  assign f_q_l = f_q_r[LW-1:0];
  assign u_q_s = u_q_r[FW-1:LW];
  assign u_q_l = u_q_r[LW-1:0];

  assign ri   = rd_r[IW-1:0];
  assign rip1 = ri + 1'b1;
  assign rip2 = ri + 2'd2;
  assign rim1 = ri - 1'b1;
  assign rim2 = ri - 2'd2;
  assign wi   = wr_r[IW-1:0];

  // Free table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmem_r[0] <= {{SW{1'b0}}, LW'(HEAP_BYTES)};
    end else if (f_we) begin
      fmem_r[f_waddr] <= f_wdata;
    end
    f_q_r <= fmem_r[f_raddr];
  end

  // Used table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (u_we) begin
      umem_r[u_waddr] <= u_wdata;
    end
    u_q_r <= umem_r[u_raddr];
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      fcnt_r     <= CW'(1);
      ucnt_r     <= '0;
      rd_r       <= '0;
      wr_r       <= '0;
      pr_r       <= 1'b0;
      type_r     <= REQ_ALLOC;
      size_r     <= '0;
      addr_r     <= '0;
      cs_r       <= '0;
      cl_r       <= '0;
      res_addr_r <= '0;
      res_stat_r <= ST_OK;
      ov_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      fcnt_r     <= fcnt_nxt;
      ucnt_r     <= ucnt_nxt;
      rd_r       <= rd_nxt;
      wr_r       <= wr_nxt;
      pr_r       <= pr_nxt;
      type_r     <= type_nxt;
      size_r     <= size_nxt;
      addr_r     <= addr_nxt;
      cs_r       <= cs_nxt;
      cl_r       <= cl_nxt;
      res_addr_r <= res_addr_nxt;
      res_stat_r <= res_stat_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // Next state: one table entry per cycle once a scan is primed. A scan that
  // reads the table first only issues a read, so read data always follows the last write.
  always_comb begin
    st_nxt       = st_r;
    fcnt_nxt     = fcnt_r;
    ucnt_nxt     = ucnt_r;
    rd_nxt       = rd_r;
    wr_nxt       = wr_r;
    pr_nxt       = pr_r;
    type_nxt     = type_r;
    size_nxt     = size_r;
    addr_nxt     = addr_r;
    cs_nxt       = cs_r;
    cl_nxt       = cl_r;
    res_addr_nxt = res_addr_r;
    res_stat_nxt = res_stat_r;
    ov_nxt       = ov_r;
    f_raddr      = '0;
    f_we         = 1'b0;
    f_waddr      = '0;
    f_wdata      = '0;
    u_raddr      = '0;
    u_we         = 1'b0;
    u_waddr      = '0;
    u_wdata      = '0;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          type_nxt     = in_req_type;
          size_nxt     = ZW'(in_req_size);
          addr_nxt     = SW'(in_req_addr);
          rd_nxt       = '0;
          wr_nxt       = '0;
          pr_nxt       = 1'b1;
          res_addr_nxt = '0;
          if (in_req_type == REQ_FREE) begin
            st_nxt = S_USRCH;
          end else if (in_req_size == '0) begin
            res_stat_nxt = ST_ZERO;
            st_nxt       = S_DONE;
          end else begin
            st_nxt = S_COAL;
          end
        end
      end
      // Merge pass: the chunk being built is held in cs/cl, written out at wr.
      S_COAL: begin
        if (pr_r) begin
          f_raddr = ri;
          pr_nxt  = 1'b0;
        end else if (rd_r < fcnt_r) begin
          if (rd_r != '0 && (cs_r + SW'(cl_r)) == f_q_s) begin
            cl_nxt = cl_r + f_q_l;
          end else begin
            if (rd_r != '0) begin
              f_we    = 1'b1;
              f_waddr = wi;
              f_wdata = {cs_r, cl_r};
              wr_nxt  = wr_r + 1'b1;
            end
            cs_nxt = f_q_s;
            cl_nxt = f_q_l;
          end
          rd_nxt  = rd_r + 1'b1;
          f_raddr = rip1;
        end else begin
          if (rd_r != '0) begin
            f_we     = 1'b1;
            f_waddr  = wi;
            f_wdata  = {cs_r, cl_r};
            fcnt_nxt = wr_r + 1'b1;
          end
          rd_nxt = '0;
          pr_nxt = 1'b1;
          st_nxt = S_FIT;
        end
      end
      // First-fit scan.
      S_FIT: begin
        if (pr_r) begin
          f_raddr = ri;
          pr_nxt  = 1'b0;
        end else if (rd_r >= fcnt_r) begin
          res_stat_nxt = ST_NOSPACE;
          st_nxt       = S_DONE;
        end else if (ZW'(f_q_l) >= size_r) begin
          if (ucnt_r >= DEPTH_C) begin
            res_stat_nxt = ST_FULL;
            st_nxt       = S_DONE;
          end else begin
            cs_nxt       = f_q_s;
            cl_nxt       = f_q_l;
            res_addr_nxt = f_q_s[AddrW-1:0];
            res_stat_nxt = ST_OK;
            pr_nxt       = 1'b1;
            st_nxt       = S_FREM;
          end
        end else begin
          rd_nxt  = rd_r + 1'b1;
          f_raddr = rip1;
        end
      end
      // Shift the free table down over the taken chunk.
      S_FREM: begin
        if (rd_r + 1'b1 >= fcnt_r) begin
          fcnt_nxt = fcnt_r - 1'b1;
          rd_nxt   = ucnt_r;
          pr_nxt   = 1'b1;
          st_nxt   = S_UINS;
        end else if (pr_r) begin
          f_raddr = rip1;
          pr_nxt  = 1'b0;
        end else begin
          f_we    = 1'b1;
          f_waddr = ri;
          f_wdata = f_q_r;
          rd_nxt  = rd_r + 1'b1;
          f_raddr = rip2;
        end
      end
      // Sorted insert of the allocated chunk into the used table.
      S_UINS: begin
        if (rd_r != '0 && pr_r) begin
          u_raddr = rim1;
          pr_nxt  = 1'b0;
        end else if (rd_r != '0 && u_q_s > cs_r) begin
          u_we    = 1'b1;
          u_waddr = ri;
          u_wdata = u_q_r;
          rd_nxt  = rd_r - 1'b1;
          u_raddr = rim2;
        end else begin
          u_we     = 1'b1;
          u_waddr  = ri;
          u_wdata  = {cs_r, LW'(size_r)};
          ucnt_nxt = ucnt_r + 1'b1;
          if (ZW'(cl_r) > size_r) begin
            cs_nxt = cs_r + SW'(size_r);
            cl_nxt = cl_r - LW'(size_r);
            rd_nxt = fcnt_r;
            pr_nxt = 1'b1;
            st_nxt = S_FINS;
          end else begin
            st_nxt = S_DONE;
          end
        end
      end
      // Sorted insert into the free table (tail or freed chunk).
      S_FINS: begin
        if (rd_r != '0 && pr_r) begin
          f_raddr = rim1;
          pr_nxt  = 1'b0;
        end else if (rd_r != '0 && f_q_s > cs_r) begin
          f_we    = 1'b1;
          f_waddr = ri;
          f_wdata = f_q_r;
          rd_nxt  = rd_r - 1'b1;
          f_raddr = rim2;
        end else begin
          f_we     = 1'b1;
          f_waddr  = ri;
          f_wdata  = {cs_r, cl_r};
          fcnt_nxt = fcnt_r + 1'b1;
          if (type_r == REQ_FREE) begin
            rd_nxt = wr_r;
            pr_nxt = 1'b1;
            st_nxt = S_UREM;
          end else begin
            st_nxt = S_DONE;
          end
        end
      end
      // Search the used table for the exact start address.
      S_USRCH: begin
        if (rd_r >= ucnt_r) begin
          res_stat_nxt = ST_NOTFOUND;
          st_nxt       = S_DONE;
        end else if (pr_r) begin
          u_raddr = ri;
          pr_nxt  = 1'b0;
        end else if (u_q_s == addr_r) begin
          if (fcnt_r >= DEPTH_C) begin
            res_stat_nxt = ST_FULL;
            st_nxt       = S_DONE;
          end else begin
            res_stat_nxt = ST_OK;
            cs_nxt       = u_q_s;
            cl_nxt       = u_q_l;
            wr_nxt       = rd_r;
            rd_nxt       = fcnt_r;
            pr_nxt       = 1'b1;
            st_nxt       = S_FINS;
          end
        end else begin
          rd_nxt  = rd_r + 1'b1;
          u_raddr = rip1;
        end
      end
      // Shift the used table down over the freed entry.
      S_UREM: begin
        if (rd_r + 1'b1 >= ucnt_r) begin
          ucnt_nxt = ucnt_r - 1'b1;
          st_nxt   = S_DONE;
        end else if (pr_r) begin
          u_raddr = rip1;
          pr_nxt  = 1'b0;
        end else begin
          u_we    = 1'b1;
          u_waddr = ri;
          u_wdata = u_q_r;
          rd_nxt  = rd_r + 1'b1;
          u_raddr = rip2;
        end
      end
      // Hold the result until the transfer completes.
      S_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
        end else if (out_ready) begin
          ov_nxt = 1'b0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

endmodule
